// ===== hw/rtl/oph_pkg.sv =====
`default_nettype none
package oph_pkg;

    localparam int MAX_LEVELS = 64;
    localparam int LEV_W      = $clog2(MAX_LEVELS);

    // luma weights, 16 fractional bits
    localparam logic [23:0] LUMA_R = 24'd19595;
    localparam logic [23:0] LUMA_G = 24'd38470;
    localparam logic [23:0] LUMA_B = 24'd7471;

    localparam logic [1:0] CFG_RADIUS = 2'd0;
    localparam logic [1:0] CFG_LEVELS = 2'd1;
    localparam logic [1:0] CFG_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_HEIGHT = 2'd3;

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_COMPUTE = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } t_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRD,
        ST_LUMA,
        ST_BKT,
        ST_HRD,
        ST_HWR,
        ST_SINIT,
        ST_SCAN,
        ST_FIN,
        ST_DINIT,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic setup;
        logic smp_rd;
        logic luma;
        logic bkt;
        logic h_rd;
        logic h_wr;
        logic scan_init;
        logic scan_step;
        logic fin_rd;
        logic div_init;
        logic div_step;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic last_smp;
        logic scan_done;
        logic div_last;
        logic ch_last;
    } t_dp_sts;

endpackage
`default_nettype wire

// ===== hw/rtl/oph_ctrl.sv =====
`default_nettype none
module oph_ctrl import oph_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire logic    i_mode,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd,
    output logic         o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_mode == MODE_COMPUTE) begin
                        o_cmd.setup = 1'b1;
                        n_state     = ST_SRD;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            ST_SRD: begin
                o_cmd.smp_rd = 1'b1;
                n_state      = ST_LUMA;
            end
            ST_LUMA: begin
                o_cmd.luma = 1'b1;
                n_state    = ST_BKT;
            end
            ST_BKT: begin
                o_cmd.bkt = 1'b1;
                n_state   = ST_HRD;
            end
            ST_HRD: begin
                o_cmd.h_rd = 1'b1;
                n_state    = ST_HWR;
            end
            ST_HWR: begin
                o_cmd.h_wr = 1'b1;
                n_state    = i_sts.last_smp ? ST_SINIT : ST_SRD;
            end
            ST_SINIT: begin
                o_cmd.scan_init = 1'b1;
                n_state         = ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.fin_rd = 1'b1;
                n_state      = ST_DINIT;
            end
            ST_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = i_sts.ch_last ? ST_EMIT : ST_DINIT;
                end
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT |=> r_state == ST_IDLE)
        else $error("emit not followed by idle");

    a_div_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && i_sts.div_last && i_sts.ch_last) |=> r_state == ST_EMIT)
        else $error("last division did not lead to emit");

    a_smp_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HWR && !i_sts.last_smp) |=> r_state == ST_SRD)
        else $error("window walk left early");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_start && i_mode == MODE_LOAD) |=> r_state == ST_IDLE)
        else $error("load beat made the block busy");

endmodule
`default_nettype wire

// ===== hw/rtl/oph_dp.sv =====
`default_nettype none
module oph_dp import oph_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_in        i_in,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [8:0] i_cfg_data,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_sts         o_sts,
    output t_out            o_out,
    output logic            o_done
);

    logic [2:0] r_radius;
    logic [6:0] r_levels;
    logic [8:0] r_iw;
    logic [8:0] r_ih;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 3'd3;
            r_levels <= 7'd20;
            r_iw     <= 9'd256;
            r_ih     <= 9'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RADIUS: r_radius <= i_cfg_data[2:0];
                CFG_LEVELS: r_levels <= i_cfg_data[6:0];
                CFG_WIDTH:  r_iw     <= i_cfg_data;
                CFG_HEIGHT: r_ih     <= i_cfg_data;
                default:    r_radius <= r_radius;
            endcase
        end
    end

    logic [6:0] nlev;
    logic [8:0] w9;
    logic [8:0] h9;
    logic [7:0] wm1;
    logic [7:0] hm1;
    logic [3:0] span;

    always_comb begin
        if (r_levels < 7'd2) begin
            nlev = 7'd2;
        end else if (r_levels > 7'(MAX_LEVELS)) begin
            nlev = 7'(MAX_LEVELS);
        end else begin
            nlev = r_levels;
        end
        w9   = (r_iw == 9'd0) ? 9'd1 : ((r_iw > 9'd256) ? 9'd256 : r_iw);
        h9   = (r_ih == 9'd0) ? 9'd1 : ((r_ih > 9'd256) ? 9'd256 : r_ih);
        wm1  = 8'(w9 - 9'd1);
        hm1  = 8'(h9 - 9'd1);
        span = {r_radius, 1'b0};
    end

    // window walk
    logic [7:0] r_cx;
    logic [7:0] r_cy;
    logic [3:0] r_i;
    logic [3:0] r_j;
    logic signed [10:0] sx_s;
    logic signed [10:0] sy_s;
    logic [7:0] sx;
    logic [7:0] sy;

    always_comb begin
        sx_s = $signed({3'b0, r_cx}) + $signed({7'b0, r_i}) - $signed({8'b0, r_radius});
        sy_s = $signed({3'b0, r_cy}) + $signed({7'b0, r_j}) - $signed({8'b0, r_radius});
        if (sx_s < 0) begin
            sx = 8'd0;
        end else if (sx_s > $signed({3'b0, wm1})) begin
            sx = wm1;
        end else begin
            sx = sx_s[7:0];
        end
        if (sy_s < 0) begin
            sy = 8'd0;
        end else if (sy_s > $signed({3'b0, hm1})) begin
            sy = hm1;
        end else begin
            sy = sy_s[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_cx <= (i_in.col > wm1) ? wm1 : i_in.col;
            r_cy <= (i_in.row > hm1) ? hm1 : i_in.row;
            r_i  <= 4'd0;
            r_j  <= 4'd0;
        end else if (i_cmd.h_wr) begin
            if (r_i == span) begin
                r_i <= 4'd0;
                r_j <= r_j + 4'd1;
            end else begin
                r_i <= r_i + 4'd1;
            end
        end
    end

    // frame store, R in the low byte
    logic [31:0] frame [0:65535];
    logic [31:0] r_fdata;
    logic [15:0] f_raddr;
    logic        f_re;

    assign f_re    = i_cmd.smp_rd | i_cmd.fin_rd;
    assign f_raddr = i_cmd.fin_rd ? {r_cy, r_cx} : {sy, sx};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            frame[{i_in.row, i_in.col}] <=
                {i_in.alpha_in, i_in.blue_in, i_in.green_in, i_in.red_in};
        end
        if (f_re) begin
            r_fdata <= frame[f_raddr];
        end
    end

    // luma and bucket
    logic [23:0]      r_luma;
    logic [LEV_W-1:0] r_bkt;
    logic [30:0]      prod;
    logic [6:0]       bk7;
    logic [6:0]       bk_cap;

    always_comb begin
        prod   = 31'(r_luma) * 31'(nlev);
        bk7    = prod[30:24];
        bk_cap = (bk7 >= nlev) ? 7'(nlev - 7'd1) : bk7;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.luma) begin
            r_luma <= 24'(r_fdata[7:0]) * LUMA_R + 24'(r_fdata[15:8]) * LUMA_G
                    + 24'(r_fdata[23:16]) * LUMA_B;
        end
        if (i_cmd.bkt) begin
            r_bkt <= bk_cap[LEV_W-1:0];
        end
    end

    // histogram: {count, red sum, green sum, blue sum}
    logic [55:0]           hist [0:MAX_LEVELS-1];
    logic [55:0]           r_hdata;
    logic                  r_hvrd;
    logic [MAX_LEVELS-1:0] r_hval;
    logic [55:0]           h_cur;
    logic [55:0]           h_wdata;
    logic [LEV_W-1:0]      h_raddr;
    logic                  h_re;
    logic                  scan_rd;
    logic [6:0]            r_sb;
    logic [LEV_W-1:0]      r_sidx;
    logic                  r_cv;
    logic [LEV_W-1:0]      r_best;
    logic [7:0]            r_bcnt;

    assign scan_rd = i_cmd.scan_step && (r_sb < nlev);
    assign h_re    = i_cmd.h_rd | scan_rd | i_cmd.fin_rd;
    assign h_cur   = r_hvrd ? r_hdata : 56'd0;

    always_comb begin
        if (i_cmd.fin_rd) begin
            h_raddr = r_best;
        end else if (scan_rd) begin
            h_raddr = r_sb[LEV_W-1:0];
        end else begin
            h_raddr = r_bkt;
        end
        h_wdata = {h_cur[55:48] + 8'd1,
                   h_cur[47:32] + {8'd0, r_fdata[7:0]},
                   h_cur[31:16] + {8'd0, r_fdata[15:8]},
                   h_cur[15:0]  + {8'd0, r_fdata[23:16]}};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.h_wr) begin
            hist[r_bkt] <= h_wdata;
        end
        if (h_re) begin
            r_hdata <= hist[h_raddr];
            r_hvrd  <= r_hval[h_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hval <= '0;
        end else if (i_cmd.setup) begin
            r_hval <= '0;
        end else if (i_cmd.h_wr) begin
            r_hval[r_bkt] <= 1'b1;
        end
    end

    // max search, strict compare keeps the lowest index on a tie
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= 1'b0;
        end else if (i_cmd.scan_init) begin
            r_cv <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_cv <= scan_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_sb   <= 7'd0;
            r_best <= '0;
            r_bcnt <= 8'd0;
        end else if (i_cmd.scan_step) begin
            if (scan_rd) begin
                r_sb   <= r_sb + 7'd1;
                r_sidx <= r_sb[LEV_W-1:0];
            end
            if (r_cv && (h_cur[55:48] > r_bcnt)) begin
                r_best <= r_sidx;
                r_bcnt <= h_cur[55:48];
            end
        end
    end

    // rounded mean, restoring division, one quotient bit a cycle
    logic [17:0] r_num;
    logic [15:0] r_dv;
    logic [7:0]  r_q;
    logic [2:0]  r_dk;
    logic [1:0]  r_ch;
    logic [7:0]  r_red;
    logic [7:0]  r_grn;
    logic [7:0]  r_blu;
    logic [15:0] sum_sel;
    logic        ge;
    logic [7:0]  q_fin;

    always_comb begin
        case (r_ch)
            2'd0:    sum_sel = h_cur[47:32];
            2'd1:    sum_sel = h_cur[31:16];
            default: sum_sel = h_cur[15:0];
        endcase
        ge    = r_num >= {2'b0, r_dv};
        q_fin = (h_cur[55:48] == 8'd0) ? 8'd0 : {r_q[6:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_ch <= 2'd0;
        end else if (i_cmd.div_init) begin
            r_num <= {1'b0, sum_sel, 1'b0} + {10'd0, h_cur[55:48]};
            r_dv  <= {h_cur[55:48], 8'd0};
            r_q   <= 8'd0;
            r_dk  <= 3'd7;
        end else if (i_cmd.div_step) begin
            if (ge) begin
                r_num <= r_num - {2'b0, r_dv};
            end
            r_dv <= r_dv >> 1;
            r_q  <= {r_q[6:0], ge};
            r_dk <= r_dk - 3'd1;
            if (r_dk == 3'd0) begin
                case (r_ch)
                    2'd0:    r_red <= q_fin;
                    2'd1:    r_grn <= q_fin;
                    default: r_blu <= q_fin;
                endcase
                r_ch <= r_ch + 2'd1;
            end
        end
    end

    logic r_ostb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ostb <= 1'b0;
        end else begin
            r_ostb <= i_cmd.emit;
        end
    end

    assign o_done          = r_ostb;
    assign o_out.red_out   = r_red;
    assign o_out.green_out = r_grn;
    assign o_out.blue_out  = r_blu;
    assign o_out.alpha_out = r_fdata[31:24];

    assign o_sts.last_smp  = (r_i == span) && (r_j == span);
    assign o_sts.scan_done = (r_sb >= nlev) && !r_cv;
    assign o_sts.div_last  = (r_dk == 3'd0);
    assign o_sts.ch_last   = (r_ch == 2'd2);

endmodule
`default_nettype wire

// ===== hw/rtl/oil_paint_histogram_filter_unit.sv =====
// Load beat: written into the frame store in the same cycle, no result, o_busy stays low.
// Compute beat: N = (2*radius+1)^2 window samples, each taken through store read, luma, bucket,
// histogram read and histogram write in turn, then a bucket scan over the levels for the fullest bucket,
// a re-read of that bucket and the centre pixel, and three 8-step divisions; then o_done is raised.
// One item at a time, the next beat can be taken in the o_done cycle; the receiver cannot stall.
// Reset (synchronous, active low) loads the default registers; the frame store is not cleared.
`default_nettype none
module oil_paint_histogram_filter_unit import oph_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire t_in        i_in,
    output logic            o_busy,
    output logic            o_done,
    output t_out            o_out,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [8:0] i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    oph_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_mode  (i_in.mode),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    oph_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out      (o_out),
        .o_done     (o_done)
    );

endmodule
`default_nettype wire
